// ===== src/sat_pkg.sv =====
// ----------------------------------------------------------------------------
// sat_pkg
// Shared types and constants of the set-associative transposition table.
// ----------------------------------------------------------------------------
package sat_pkg;

  localparam int CLUSTER_COUNT = 1024;
  localparam int WAYS          = 4;
  localparam int CLUSTER_BITS  = (CLUSTER_COUNT > 1) ? $clog2(CLUSTER_COUNT) : 1;
  localparam int WAY_BITS      = (WAYS > 1) ? $clog2(WAYS) : 1;

  localparam int EXACT_BONUS   = 8;
  localparam int AGE_WEIGHT    = 16;
  localparam int AGE_SHIFT     = $clog2(AGE_WEIGHT);
  localparam int WORTH_W       = 14;

  localparam int S_DATA_W      = 112;
  localparam int S_USER_W      = 2;
  localparam int M_DATA_W      = 48;

  localparam logic [1:0] BOUND_EXACT = 2'd0;

  typedef enum logic [1:0] {
    FUNC_PROBE   = 2'd0,
    FUNC_STORE   = 2'd1,
    FUNC_ADVANCE = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] key;
    logic [15:0] score;
    logic [15:0] move;
    logic [7:0]  depth;
    logic [7:0]  age;
    logic [1:0]  bound;
  } way_t;

  localparam int ROW_W = WAYS * $bits(way_t);

  typedef struct packed {
    logic clear_we;
    logic load;
    logic execute;
  } sat_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_stall;
  } sat_status_t;

endpackage

// ===== src/set_assoc_transposition_table.sv =====
// ----------------------------------------------------------------------------
// set_assoc_transposition_table
// Four-way transposition table with depth and age based replacement.
// ----------------------------------------------------------------------------
// Input stream carries one command per transaction: s_tuser selects probe,
// store or advance generation; s_tdata carries key, depth, score, bound and
// move. Every command returns exactly one transaction on the output stream:
// m_tuser is the hit flag, m_tdata the stored score, depth, bound and move
// of the matching way on a probe hit, zero otherwise.
// Each command reads the key's cluster row from the cluster memory, then
// compares the ways, writes the row back on a store and loads the
// result register. A new command is not accepted until the current one
// has loaded its result, as s_tready is high only while idle.
// The next command is accepted while a result still waits in the output
// register; if the receiver keeps m_tready low, processing holds in the
// lookup step until the result register frees up.
// After reset the table clears itself, one cluster row per cycle, over
// all 1024 cluster rows; s_tready stays low during that sweep.
// ----------------------------------------------------------------------------
module set_assoc_transposition_table
  import sat_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // hash_key[63:0], search_depth[71:64], value_score[87:72],
  // bound_kind[89:88], best_move_code[105:90], zero pad
  input  logic [S_DATA_W-1:0] s_tdata,
  // func[1:0]
  input  logic [S_USER_W-1:0] s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  // hit_score[15:0], hit_depth[23:16], hit_bound[25:24], hit_move[41:26],
  // zero pad
  output logic [M_DATA_W-1:0] m_tdata,
  // hit
  output logic                m_tuser
);

  sat_cmd_t    cmd;
  sat_status_t status;

  sat_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  sat_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// ===== src/sat_ram.sv =====
// ----------------------------------------------------------------------------
// sat_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/sat_ctrl.sv =====
// ----------------------------------------------------------------------------
// sat_ctrl
// Controller: clearing sweep, input accept and lookup/write-back sequencing.
// ----------------------------------------------------------------------------
module sat_ctrl
  import sat_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  sat_status_t status,
  output sat_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    s_tready     = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_we = 1'b1;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (!status.out_stall) begin
          cmd.execute = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

// ===== src/sat_datapath.sv =====
// ----------------------------------------------------------------------------
// sat_datapath
// Cluster memory, way compare, replacement choice and result register.
// ----------------------------------------------------------------------------
module sat_datapath
  import sat_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  sat_cmd_t            cmd,
  output sat_status_t         status,
  input  logic [S_DATA_W-1:0] s_tdata,
  input  logic [S_USER_W-1:0] s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,
  output logic                m_tuser
);

  logic [1:0]              func_q;
  logic [63:0]             key_q;
  logic [7:0]              depth_q;
  logic [15:0]             score_q;
  logic [1:0]              bound_q;
  logic [15:0]             move_q;
  logic [7:0]              generation;
  logic [CLUSTER_BITS-1:0] clr_addr;

  logic                    ram_we;
  logic [CLUSTER_BITS-1:0] ram_waddr;
  logic [ROW_W-1:0]        ram_wdata;
  logic [ROW_W-1:0]        ram_rdata;

  way_t [WAYS-1:0]         ways;
  way_t [WAYS-1:0]         row_next;
  way_t                    fill;
  logic                    hit_any;
  logic [WAY_BITS-1:0]     hit_idx;
  logic                    empty_any;
  logic [WAY_BITS-1:0]     empty_idx;
  logic [WAY_BITS-1:0]     victim;
  logic signed [WORTH_W-1:0] worth [WAYS];
  logic signed [WORTH_W-1:0] best;
  logic [7:0]              age;
  logic                    res_hit;
  logic [M_DATA_W-1:0]     res_data;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q  <= s_tuser;
      key_q   <= s_tdata[63:0];
      depth_q <= s_tdata[71:64];
      score_q <= s_tdata[87:72];
      bound_q <= s_tdata[89:88];
      move_q  <= s_tdata[105:90];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      generation <= '0;
      clr_addr   <= '0;
    end else begin
      if (cmd.clear_we) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.execute && func_q == FUNC_ADVANCE) begin
        generation <= generation + 8'd1;
      end
    end
  end

  assign status.clear_last = (clr_addr == CLUSTER_BITS'(CLUSTER_COUNT - 1));
  assign status.out_stall  = m_tvalid && !m_tready;

  assign ram_we    = cmd.clear_we || (cmd.execute && func_q == FUNC_STORE);
  assign ram_waddr = cmd.clear_we ? clr_addr : key_q[CLUSTER_BITS-1:0];
  assign ram_wdata = cmd.clear_we ? '0 : ROW_W'(row_next);

  sat_ram #(
    .WIDTH (ROW_W),
    .DEPTH (CLUSTER_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.load),
    .raddr (s_tdata[CLUSTER_BITS-1:0]),
    .rdata (ram_rdata)
  );

  assign ways = ram_rdata;

  always_comb begin
    hit_any   = 1'b0;
    hit_idx   = '0;
    empty_any = 1'b0;
    empty_idx = '0;
    age       = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (ways[w].valid && ways[w].key == key_q && !hit_any) begin
        hit_any = 1'b1;
        hit_idx = WAY_BITS'(w);
      end
      if (!ways[w].valid && !empty_any) begin
        empty_any = 1'b1;
        empty_idx = WAY_BITS'(w);
      end
      age      = generation - ways[w].age;
      worth[w] = WORTH_W'(ways[w].depth)
               + ((ways[w].bound == BOUND_EXACT) ? WORTH_W'(EXACT_BONUS) : WORTH_W'(0))
               - (WORTH_W'(age) << AGE_SHIFT);
    end
    best   = worth[0];
    victim = '0;
    for (int w = 1; w < WAYS; w++) begin
      if (worth[w] < best) begin
        best   = worth[w];
        victim = WAY_BITS'(w);
      end
    end
  end

  always_comb begin
    fill.valid = 1'b1;
    fill.key   = key_q;
    fill.score = score_q;
    fill.move  = move_q;
    fill.depth = depth_q;
    fill.age   = generation;
    fill.bound = bound_q;
    row_next   = ways;
    if (hit_any) begin
      if (depth_q >= ways[hit_idx].depth || bound_q == BOUND_EXACT) begin
        row_next[hit_idx] = fill;
      end else begin
        row_next[hit_idx].age = generation;
      end
    end else if (empty_any) begin
      row_next[empty_idx] = fill;
    end else begin
      row_next[victim] = fill;
    end
  end

  always_comb begin
    res_hit  = 1'b0;
    res_data = '0;
    case (func_q)
      FUNC_PROBE: begin
        res_hit = hit_any;
        if (hit_any) begin
          res_data = {6'b0, ways[hit_idx].move, ways[hit_idx].bound,
                      ways[hit_idx].depth, ways[hit_idx].score};
        end
      end
      FUNC_STORE: begin
        res_hit = hit_any;
      end
      default: begin
        res_hit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.execute) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      m_tdata <= res_data;
      m_tuser <= res_hit;
    end
  end

endmodule
